// ----- sv/tcf_pkg.sv -----
// ----------------------------------------------------------------------------
// tcf_pkg: shared definitions for the text_cat_filter byte filter
// Character codes, register indexes, line number width and BCD helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package tcf_pkg;

  localparam int NUM_DIGITS = 6;
  localparam int LN_W       = 4 * NUM_DIGITS;
  localparam int BUF_LEN    = NUM_DIGITS + 3;
  localparam int POS_W      = $clog2(BUF_LEN);

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOLL  = 8'h24;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_SPC   = 8'h20;
  localparam logic [7:0] CTRL_OFS = 8'h40;

  localparam logic [1:0] BR_TEXT  = 2'd0;
  localparam logic [1:0] BR_HIDE  = 2'd1;
  localparam logic [1:0] BR_SHOWN = 2'd2;

  typedef enum logic [2:0] {
    REG_NUMBER_NONBLANK  = 3'd0,
    REG_NUMBER_ALL       = 3'd1,
    REG_SQUEEZE_BLANK    = 3'd2,
    REG_SHOW_ENDS        = 3'd3,
    REG_SHOW_TABS        = 3'd4,
    REG_SHOW_NONPRINTING = 3'd5
  } reg_idx_t;

  // saturating BCD increment
  function automatic logic [LN_W-1:0] bcd_inc(input logic [LN_W-1:0] v);
    logic [LN_W-1:0] r;
    logic            carry;
    r     = v;
    carry = 1'b1;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (carry) begin
        if (v[4*i +: 4] == 4'd9) begin
          r[4*i +: 4] = 4'd0;
        end else begin
          r[4*i +: 4] = v[4*i +: 4] + 4'd1;
          carry       = 1'b0;
        end
      end
    end
    return carry ? v : r;
  endfunction

  function automatic logic [LN_W-1:0] bcd_one();
    logic [LN_W-1:0] r;
    r = '0;
    r[0] = 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/text_cat_filter.sv -----
// ----------------------------------------------------------------------------
// text_cat_filter: cat-style byte stream filter
// An accepted input word's first output word is valid in the next cycle.
// While m_tready is high: one input word per cycle if each byte yields at
// most one output word; a byte yielding more holds the input until its last
// word leaves the single output expansion register, emitting one per cycle.
// Reset (rst, synchronous): options off, line state restarted, output empty.
// ----------------------------------------------------------------------------
`default_nettype none

module text_cat_filter import tcf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] in_byte
  input  wire logic       s_tuser,   // [0] file_start
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] out_byte
  output logic            m_tlast,   // last
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [0:0] cfg_data
);

  logic number_nonblank, number_all, squeeze_blank;
  logic show_ends, show_tabs, show_nonprinting;

  logic            at_line_start;
  logic [1:0]      blank_run;
  logic [LN_W-1:0] line_number;

  logic [7:0]       jbuf [BUF_LEN];
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] stop;

  // per-word decode
  logic            at, nl, shown, num, glen2, accept, emit_done;
  logic [1:0]      br, br_next;
  logic [LN_W-1:0] ln;
  logic [7:0]      g0, g1;
  logic [7:0]      nbuf [BUF_LEN];
  logic            nz;
  logic [3:0]      dig;

  assign nl        = (s_tdata == CH_NL);
  assign at        = s_tuser | at_line_start;
  assign br        = s_tuser ? BR_TEXT : blank_run;
  assign ln        = s_tuser ? bcd_one() : line_number;
  assign emit_done = m_tvalid & m_tready & (pos == stop);
  assign s_tready  = ~m_tvalid | emit_done;
  assign accept    = s_tvalid & s_tready;

  always_comb begin
    if (!squeeze_blank) begin
      br_next = BR_TEXT;
    end else if (at) begin
      br_next = nl ? ((br == BR_TEXT) ? BR_SHOWN : BR_HIDE) : BR_TEXT;
    end else begin
      br_next = br;
    end
  end

  assign shown = (br_next == BR_TEXT) | (br_next == BR_SHOWN);
  assign num   = shown & at & ((number_nonblank & ~nl) | (number_all & ~number_nonblank));

  always_comb begin
    g0    = s_tdata;
    g1    = s_tdata;
    glen2 = 1'b0;
    priority if (show_tabs && s_tdata == CH_TAB) begin
      g0 = CH_CARET; g1 = CH_I; glen2 = 1'b1;
    end else if (show_ends && nl) begin
      g0 = CH_DOLL; g1 = CH_NL; glen2 = 1'b1;
    end else if (show_nonprinting && s_tdata < CH_SPC && !nl && s_tdata != CH_TAB) begin
      g0 = CH_CARET; g1 = s_tdata + CTRL_OFS; glen2 = 1'b1;
    end else if (show_nonprinting && s_tdata == CH_DEL) begin
      g0 = CH_CARET; g1 = CH_QUEST; glen2 = 1'b1;
    end else begin
      g0 = s_tdata;
    end
  end

  // number field: leading zeros shown as spaces
  always_comb begin
    nz  = 1'b0;
    dig = '0;
    for (int j = 0; j < NUM_DIGITS; j++) begin
      dig = ln[4*(NUM_DIGITS-1-j) +: 4];
      nz  = nz | (dig != 4'd0);
      nbuf[j] = nz ? (CH_ZERO + {4'd0, dig}) : CH_SPACE;
    end
    nbuf[NUM_DIGITS]   = CH_TAB;
    nbuf[NUM_DIGITS+1] = g0;
    nbuf[NUM_DIGITS+2] = g1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      number_nonblank  <= 1'b0;
      number_all       <= 1'b0;
      squeeze_blank    <= 1'b0;
      show_ends        <= 1'b0;
      show_tabs        <= 1'b0;
      show_nonprinting <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NUMBER_NONBLANK:  number_nonblank  <= cfg_data[0];
        REG_NUMBER_ALL:       number_all       <= cfg_data[0];
        REG_SQUEEZE_BLANK:    squeeze_blank    <= cfg_data[0];
        REG_SHOW_ENDS:        show_ends        <= cfg_data[0];
        REG_SHOW_TABS:        show_tabs        <= cfg_data[0];
        REG_SHOW_NONPRINTING: show_nonprinting <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      at_line_start <= 1'b1;
      blank_run     <= BR_TEXT;
      line_number   <= bcd_one();
    end else if (accept) begin
      at_line_start <= nl;
      blank_run     <= br_next;
      line_number   <= num ? bcd_inc(ln) : ln;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      pos      <= '0;
      stop     <= '0;
    end else if (accept && shown) begin
      m_tvalid <= 1'b1;
      pos      <= num ? POS_W'(0) : POS_W'(NUM_DIGITS + 1);
      stop     <= glen2 ? POS_W'(NUM_DIGITS + 2) : POS_W'(NUM_DIGITS + 1);
    end else if (emit_done) begin
      m_tvalid <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      pos <= pos + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && shown) begin
      jbuf <= nbuf;
    end
  end

  assign m_tdata = jbuf[pos];
  assign m_tlast = (pos == stop);

endmodule

`default_nettype wire

// ----- sv/tcf_checker.sv -----
// ----------------------------------------------------------------------------
// tcf_checker: port-level checks for text_cat_filter
// Output hold under stall, reset state, idle ready and expansion run behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module tcf_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_tready,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic       m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed under stall");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  a_run_cont: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    else $error("word run broken before last");

  a_run_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input taken mid run");

endmodule

bind text_cat_filter tcf_checker u_tcf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire
